### hdl/rpn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared widths, token and status codes, and the arithmetic unit's command
// type for the reverse Polish stack calculator.
// ----------------------------------------------------------------------------
package rpn_pkg;

   // word field widths
   localparam int DATA_W  = 32;
   localparam int MODE_W  = 3;
   localparam int STAT_W  = 3;
   localparam int DEPTH_W = 7;

   // default number of stack entries
   localparam int STACK_DEPTH_DEF = 64;

   // token codes
   localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ADD    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SUB    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_MUL    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DIV    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_FINISH = 3'd5;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
   localparam logic [STAT_W-1:0] ST_UNDER   = 3'd1;
   localparam logic [STAT_W-1:0] ST_OVER    = 3'd2;
   localparam logic [STAT_W-1:0] ST_DIVZ    = 3'd3;
   localparam logic [STAT_W-1:0] ST_INVALID = 3'd4;
   localparam logic [STAT_W-1:0] ST_HALTED  = 3'd5;

   // arithmetic unit operations
   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   // command from the sequencer to the arithmetic unit
   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_cmd_type;

endpackage

### hdl/rpn_stack_calculator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_calculator_core
// Reverse Polish calculator on Q16.16 fixed point with a stack memory and
// a serial arithmetic unit.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one token word (mode, number_value); rsp_ channel
//   returns one word per token (status, result_value, stack_depth).
//   A word moves when valid is high and stall is low at a clock edge.
//   One token is worked on at a time; req_stall is high while it is busy.
//   A token steps through fetch, execute and emit states; unless halted,
//   add, subtract, multiply and a divide by a nonzero value also wait for
//   the serial arithmetic unit, which works one bit per cycle. A new token
//   is taken the cycle after its response is registered, while that
//   response may still wait in the output register.
//   If the receiver stalls, the response holds and the next token's response
//   waits until the output register is free.
//   Reset empties the stack and clears the halted state; stack memory
//   contents are not cleared.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_core #(
   parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [rpn_pkg::MODE_W-1:0]           req_mode,
   input  logic signed [rpn_pkg::DATA_W-1:0]    req_number_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [rpn_pkg::STAT_W-1:0]           rsp_status,
   output logic signed [rpn_pkg::DATA_W-1:0]    rsp_result_value,
   output logic [rpn_pkg::DEPTH_W-1:0]          rsp_stack_depth
);

   localparam int AW  = $clog2(STACK_DEPTH);
   localparam int SPW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_EXEC,
      S_ALU_WAIT,
      S_EMIT
   } state_type;

   state_type                     state_ff;
   logic [SPW-1:0]                sp_ff;
   logic                          halted_ff;
   logic [rpn_pkg::MODE_W-1:0]    mode_ff;
   logic [rpn_pkg::DATA_W-1:0]    num_ff;
   logic [rpn_pkg::DATA_W-1:0]    top_ff;
   logic [rpn_pkg::DATA_W-1:0]    value_ff;
   logic                          use_top_ff;
   logic [rpn_pkg::STAT_W-1:0]    status_ff;
   logic                          rsp_valid_ff;
   logic [rpn_pkg::STAT_W-1:0]    rsp_status_ff;
   logic [rpn_pkg::DATA_W-1:0]    rsp_value_ff;
   logic [rpn_pkg::DEPTH_W-1:0]   rsp_depth_ff;

   // stack storage
   logic [rpn_pkg::DATA_W-1:0]    stack_mem_ff [STACK_DEPTH];
   logic [rpn_pkg::DATA_W-1:0]    rd_data_ff;

   logic                          sp_nz;
   logic                          sp_ge2;
   logic                          sp_room;
   logic [SPW-1:0]                sp_m1;
   logic [SPW-1:0]                sp_m2;
   logic [AW-1:0]                 rd_addr;
   logic [AW-1:0]                 alu_waddr;
   logic                          wr_en;
   logic [AW-1:0]                 wr_addr;
   logic [rpn_pkg::DATA_W-1:0]    wr_data;
   logic [SPW+rpn_pkg::DEPTH_W-1:0] depth_wide;
   logic                          can_emit;
   logic [rpn_pkg::STAT_W-1:0]    status_in;
   logic                          use_top_in;

   rpn_pkg::alu_cmd_type          alu_cmd;
   logic                          needs_alu;
   logic signed [rpn_pkg::DATA_W-1:0] alu_opa;
   logic signed [rpn_pkg::DATA_W-1:0] alu_opb;
   logic                          alu_done;
   logic signed [rpn_pkg::DATA_W-1:0] alu_result;

   // stack pointer views
   always_comb begin
      sp_nz      = (sp_ff != '0);
      sp_ge2     = (sp_ff >= SPW'(2));
      sp_room    = (sp_ff < SPW'(STACK_DEPTH));
      sp_m1      = sp_ff - SPW'(1);
      sp_m2      = sp_ff - SPW'(2);
      rd_addr    = sp_m2[AW-1:0];
      alu_waddr  = sp_ge2 ? sp_m2[AW-1:0] : '0;
      depth_wide = (SPW + rpn_pkg::DEPTH_W)'(sp_ff);
      can_emit   = !rsp_valid_ff || !rsp_stall;
   end

   // operands and command for the arithmetic unit
   always_comb begin
      alu_opa   = sp_ge2 ? rd_data_ff : '0;
      alu_opb   = sp_nz ? top_ff : '0;
      needs_alu = 1'b0;
      alu_cmd.op = rpn_pkg::ALU_ADD;
      case (mode_ff)
         rpn_pkg::MODE_ADD: begin
            needs_alu  = 1'b1;
            alu_cmd.op = rpn_pkg::ALU_ADD;
         end
         rpn_pkg::MODE_SUB: begin
            needs_alu  = 1'b1;
            alu_cmd.op = rpn_pkg::ALU_SUB;
         end
         rpn_pkg::MODE_MUL: begin
            needs_alu  = 1'b1;
            alu_cmd.op = rpn_pkg::ALU_MUL;
         end
         rpn_pkg::MODE_DIV: begin
            needs_alu  = sp_nz && (top_ff != '0);
            alu_cmd.op = rpn_pkg::ALU_DIV;
         end
         default: needs_alu = 1'b0;
      endcase
      alu_cmd.start = (state_ff == S_EXEC) && !halted_ff && needs_alu;
   end

   // status and value source of the token in the execute cycle
   always_comb begin
      status_in  = rpn_pkg::ST_OK;
      use_top_in = 1'b1;
      if (halted_ff) begin
         status_in = rpn_pkg::ST_HALTED;
      end else begin
         case (mode_ff)
            rpn_pkg::MODE_PUSH: begin
               if (!sp_room) begin
                  status_in = rpn_pkg::ST_OVER;
               end
            end
            rpn_pkg::MODE_ADD, rpn_pkg::MODE_SUB, rpn_pkg::MODE_MUL: begin
               if (!sp_ge2) begin
                  status_in = rpn_pkg::ST_UNDER;
               end
            end
            rpn_pkg::MODE_DIV: begin
               // empty stack reports underflow; a zero divisor wins over a missing dividend
               if (!sp_nz) begin
                  status_in = rpn_pkg::ST_UNDER;
               end else if (top_ff == '0) begin
                  status_in = rpn_pkg::ST_DIVZ;
               end else if (!sp_ge2) begin
                  status_in = rpn_pkg::ST_UNDER;
               end
            end
            rpn_pkg::MODE_FINISH: begin
               use_top_in = 1'b0;
               if (!sp_nz) begin
                  status_in = rpn_pkg::ST_UNDER;
               end
            end
            default: status_in = rpn_pkg::ST_INVALID;
         endcase
      end
   end

   // memory write selection: push or arithmetic result
   always_comb begin
      if (state_ff == S_ALU_WAIT) begin
         wr_en   = alu_done;
         wr_addr = alu_waddr;
         wr_data = alu_result;
      end else begin
         wr_en   = (state_ff == S_EXEC) && !halted_ff
                   && (mode_ff == rpn_pkg::MODE_PUSH) && sp_room;
         wr_addr = sp_ff[AW-1:0];
         wr_data = num_ff;
      end
   end

   // stack memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= stack_mem_ff[rd_addr];
   end

   rpn_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (alu_cmd),
      .opa    (alu_opa),
      .opb    (alu_opb),
      .done   (alu_done),
      .result (alu_result)
   );

   // token sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // an emitting cycle reloads the register instead
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  mode_ff  <= req_mode;
                  num_ff   <= req_number_value;
                  state_ff <= S_FETCH;
               end
            end
            S_FETCH: begin
               // second entry from the top is read during this cycle
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               use_top_ff <= use_top_in;
               status_ff  <= status_in;
               state_ff   <= (!halted_ff && needs_alu) ? S_ALU_WAIT : S_EMIT;
               if (!halted_ff) begin
                  case (mode_ff)
                     rpn_pkg::MODE_PUSH: begin
                        if (sp_room) begin
                           top_ff <= num_ff;
                           sp_ff  <= sp_ff + SPW'(1);
                        end
                     end
                     rpn_pkg::MODE_ADD, rpn_pkg::MODE_SUB, rpn_pkg::MODE_MUL: begin
                        // operands go to the arithmetic unit this cycle
                     end
                     rpn_pkg::MODE_DIV: begin
                        if (sp_nz && (top_ff == '0)) begin
                           // zero divisor is dropped, dividend stays
                           sp_ff  <= sp_m1;
                           top_ff <= rd_data_ff;
                        end
                     end
                     rpn_pkg::MODE_FINISH: begin
                        if (sp_nz) begin
                           value_ff <= top_ff;
                           sp_ff    <= sp_m1;
                           top_ff   <= rd_data_ff;
                        end else begin
                           value_ff <= '0;
                        end
                     end
                     default: halted_ff <= 1'b1;
                  endcase
               end
            end
            S_ALU_WAIT: begin
               if (alu_done) begin
                  top_ff   <= alu_result;
                  sp_ff    <= SPW'(alu_waddr) + SPW'(1);
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (can_emit) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_value_ff  <= use_top_ff ? (sp_nz ? top_ff : '0) : value_ff;
                  rsp_depth_ff  <= depth_wide[rpn_pkg::DEPTH_W-1:0];
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_stack_depth  = rsp_depth_ff;

`ifndef ASSERT_OFF
   // stack pointer never passes the stack size
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SPW'(STACK_DEPTH))
      else $error("stack pointer beyond stack size");

   // halted state holds until reset
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halted state cleared without reset");

   // a halted status word only comes from a halted block
   a_halt_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == rpn_pkg::ST_HALTED)) |-> halted_ff)
      else $error("halted status while not halted");

   // arithmetic results only arrive while the sequencer waits for them
   a_alu_done: assert property (@(posedge clock) disable iff (reset)
      alu_done |-> (state_ff == S_ALU_WAIT))
      else $error("arithmetic result with no waiting token");
`endif

endmodule

### hdl/rpn_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_alu
// Serial Q16.16 arithmetic unit: bit-serial add/subtract, shift-add
// multiply and restoring divide, one bit per cycle, with saturation.
// ----------------------------------------------------------------------------
module rpn_alu (
   input  logic                                clock,
   input  logic                                reset,
   input  rpn_pkg::alu_cmd_type                cmd,
   input  logic signed [rpn_pkg::DATA_W-1:0]   opa,
   input  logic signed [rpn_pkg::DATA_W-1:0]   opb,
   output logic                                done,
   output logic signed [rpn_pkg::DATA_W-1:0]   result
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_SAT
   } state_type;

   localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
   localparam logic [31:0] SAT_MIN = 32'h8000_0000;

   state_type           state_ff;
   rpn_pkg::alu_op_type op_ff;
   logic [5:0]          cnt_ff;
   logic [33:0]         acc_ff;
   logic [47:0]         x_ff;
   logic [33:0]         y_ff;
   logic                carry_ff;
   logic                negq_ff;
   logic                done_ff;
   logic [31:0]         result_ff;

   logic        add_s;
   logic        add_c;
   logic [33:0] mul_sum;
   logic [32:0] div_r;
   logic [33:0] div_diff;
   logic [31:0] abs_a;
   logic [31:0] abs_b;
   logic [31:0] sat_val;
   logic [31:0] qneg;

   // operand magnitudes for the divider
   always_comb begin
      abs_a = opa[31] ? (~opa + 32'd1) : opa;
      abs_b = opb[31] ? (~opb + 32'd1) : opb;
   end

   // one serial step of each operation
   always_comb begin
      add_s = x_ff[0] ^ y_ff[0] ^ carry_ff;
      add_c = (x_ff[0] & y_ff[0]) | (x_ff[0] & carry_ff) | (y_ff[0] & carry_ff);
      if (!x_ff[0]) begin
         mul_sum = acc_ff;
      end else if (cnt_ff == 6'd1) begin
         mul_sum = acc_ff - y_ff;
      end else begin
         mul_sum = acc_ff + y_ff;
      end
      div_r    = {acc_ff[31:0], x_ff[47]};
      div_diff = {1'b0, div_r} - y_ff;
   end

   // saturate the finished value
   always_comb begin
      qneg = ~x_ff[31:0] + 32'd1;
      case (op_ff)
         rpn_pkg::ALU_ADD, rpn_pkg::ALU_SUB: begin
            if (acc_ff[32] != acc_ff[31]) begin
               sat_val = acc_ff[32] ? SAT_MIN : SAT_MAX;
            end else begin
               sat_val = acc_ff[31:0];
            end
         end
         rpn_pkg::ALU_MUL: begin
            // product is {acc[31:0], x[31:0]}; floor shift by 16
            if (acc_ff[31:15] != {17{acc_ff[31]}}) begin
               sat_val = acc_ff[31] ? SAT_MIN : SAT_MAX;
            end else begin
               sat_val = {acc_ff[15:0], x_ff[31:16]};
            end
         end
         rpn_pkg::ALU_DIV: begin
            if (negq_ff) begin
               if ((|x_ff[47:32]) || (x_ff[31] && (|x_ff[30:0]))) begin
                  sat_val = SAT_MIN;
               end else begin
                  sat_val = qneg;
               end
            end else if (|x_ff[47:31]) begin
               sat_val = SAT_MAX;
            end else begin
               sat_val = x_ff[31:0];
            end
         end
         default: sat_val = SAT_MAX;
      endcase
   end

   // sequencer and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == S_SAT);
         case (state_ff)
            S_IDLE: begin
               if (cmd.start) begin
                  op_ff    <= cmd.op;
                  acc_ff   <= '0;
                  negq_ff  <= opa[31] ^ opb[31];
                  state_ff <= S_RUN;
                  case (cmd.op)
                     rpn_pkg::ALU_ADD: begin
                        x_ff     <= {{16{opa[31]}}, opa};
                        y_ff     <= {{2{opb[31]}}, opb};
                        carry_ff <= 1'b0;
                        cnt_ff   <= 6'd33;
                     end
                     rpn_pkg::ALU_SUB: begin
                        x_ff     <= {{16{opa[31]}}, opa};
                        y_ff     <= ~{{2{opb[31]}}, opb};
                        carry_ff <= 1'b1;
                        cnt_ff   <= 6'd33;
                     end
                     rpn_pkg::ALU_MUL: begin
                        x_ff     <= {16'd0, opb};
                        y_ff     <= {{2{opa[31]}}, opa};
                        carry_ff <= 1'b0;
                        cnt_ff   <= 6'd32;
                     end
                     default: begin
                        x_ff     <= {abs_a, 16'd0};
                        y_ff     <= {2'b00, abs_b};
                        carry_ff <= 1'b0;
                        cnt_ff   <= 6'd48;
                     end
                  endcase
               end
            end
            S_RUN: begin
               case (op_ff)
                  rpn_pkg::ALU_ADD, rpn_pkg::ALU_SUB: begin
                     // sum bits enter at the top, lsb first
                     acc_ff   <= {1'b0, add_s, acc_ff[32:1]};
                     x_ff     <= {1'b0, x_ff[47:1]};
                     y_ff     <= {1'b0, y_ff[33:1]};
                     carry_ff <= add_c;
                  end
                  rpn_pkg::ALU_MUL: begin
                     acc_ff <= {mul_sum[33], mul_sum[33:1]};
                     x_ff   <= {16'd0, mul_sum[0], x_ff[31:1]};
                  end
                  default: begin
                     if (!div_diff[33]) begin
                        acc_ff <= {1'b0, div_diff[32:0]};
                        x_ff   <= {x_ff[46:0], 1'b1};
                     end else begin
                        acc_ff <= {1'b0, div_r};
                        x_ff   <= {x_ff[46:0], 1'b0};
                     end
                  end
               endcase
               cnt_ff <= cnt_ff - 6'd1;
               if (cnt_ff == 6'd1) begin
                  state_ff <= S_SAT;
               end
            end
            S_SAT: begin
               result_ff <= sat_val;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

### bench/rpn_stack_calculator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_calculator_core_tb
// Self-checking bench for the reverse Polish calculator core. A local model
// of the stack follows every accepted token word and queues the answer word
// it should produce. A checker compares each response word, field by field,
// with the oldest queued answer. Directed tokens hit saturation, rounding,
// underflow, divide by zero and the halt; random expressions, noise and
// stack fills follow. Both channels idle at random.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_core_tb;

   localparam int STACK_DEPTH   = rpn_pkg::STACK_DEPTH_DEF;
   localparam int RANDOM_TOKENS = 750;
   localparam int IDLE_LIMIT    = 2000;
   localparam int DRAIN_CYCLES  = 60;

   // modes with no operation behind them
   localparam logic [rpn_pkg::MODE_W-1:0] MODE_ILLEGAL_LO = 3'd6;
   localparam logic [rpn_pkg::MODE_W-1:0] MODE_ILLEGAL_HI = 3'd7;

   // Q16.16 landmarks
   localparam logic signed [rpn_pkg::DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [rpn_pkg::DATA_W-1:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [rpn_pkg::DATA_W-1:0] Q_ONE = 32'sh0001_0000;

   typedef struct packed {
      logic [rpn_pkg::STAT_W-1:0]  status;
      logic [rpn_pkg::DATA_W-1:0]  value;
      logic [rpn_pkg::DEPTH_W-1:0] depth;
   } answer_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [rpn_pkg::MODE_W-1:0]        req_mode = rpn_pkg::MODE_PUSH;
   logic signed [rpn_pkg::DATA_W-1:0] req_number_value = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [rpn_pkg::STAT_W-1:0]        rsp_status;
   logic signed [rpn_pkg::DATA_W-1:0] rsp_result_value;
   logic [rpn_pkg::DEPTH_W-1:0]       rsp_stack_depth;

   // stack model
   logic signed [rpn_pkg::DATA_W-1:0] calc_stack [STACK_DEPTH];
   int                                calc_depth = 0;
   bit                                calc_halted = 1'b0;

   answer_type pending_answers [$];
   int         mismatches = 0;
   int         tokens_sent = 0;
   int         burst_left = 0;
   int         idle_cycles = 0;

   rpn_stack_calculator_core #(
      .STACK_DEPTH(STACK_DEPTH)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_number_value (req_number_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_result_value (rsp_result_value),
      .rsp_stack_depth  (rsp_stack_depth)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // stack model
   // ------------------------------------------------------------------------
   function automatic logic signed [rpn_pkg::DATA_W-1:0] clamp32(input longint v);
      if (v > longint'(Q_MAX)) return Q_MAX;
      if (v < longint'(Q_MIN)) return Q_MIN;
      return v[rpn_pkg::DATA_W-1:0];
   endfunction

   // an empty pop reads as zero and marks underflow
   function automatic logic signed [rpn_pkg::DATA_W-1:0] calc_pop(inout bit under);
      if (calc_depth == 0) begin
         under = 1'b1;
         return '0;
      end
      calc_depth--;
      return calc_stack[calc_depth];
   endfunction

   function automatic void calc_push(input logic signed [rpn_pkg::DATA_W-1:0] v);
      if (calc_depth < STACK_DEPTH) begin
         calc_stack[calc_depth] = v;
         calc_depth++;
      end
   endfunction

   function automatic answer_type calc_step(
      input logic [rpn_pkg::MODE_W-1:0]        mode,
      input logic signed [rpn_pkg::DATA_W-1:0] num);
      answer_type                        ans;
      bit                                under;
      bit                                use_top;
      logic signed [rpn_pkg::DATA_W-1:0] a;
      logic signed [rpn_pkg::DATA_W-1:0] b;
      logic signed [rpn_pkg::DATA_W-1:0] value;
      longint                            prod;
      under = 1'b0;
      use_top = 1'b1;
      value = '0;
      ans.status = rpn_pkg::ST_OK;
      if (calc_halted) begin
         ans.status = rpn_pkg::ST_HALTED;
      end else begin
         case (mode)
            rpn_pkg::MODE_PUSH: begin
               if (calc_depth < STACK_DEPTH) calc_push(num);
               else ans.status = rpn_pkg::ST_OVER;
            end
            rpn_pkg::MODE_ADD: begin
               b = calc_pop(under);
               a = calc_pop(under);
               calc_push(clamp32(longint'(a) + longint'(b)));
            end
            rpn_pkg::MODE_SUB: begin
               b = calc_pop(under);
               a = calc_pop(under);
               calc_push(clamp32(longint'(a) - longint'(b)));
            end
            rpn_pkg::MODE_MUL: begin
               b = calc_pop(under);
               a = calc_pop(under);
               // arithmetic shift rounds toward minus infinity
               prod = longint'(a) * longint'(b);
               calc_push(clamp32(prod >>> 16));
            end
            rpn_pkg::MODE_DIV: begin
               // a zero divisor is dropped and the dividend stays
               b = calc_pop(under);
               if (b != 0) begin
                  a = calc_pop(under);
                  calc_push(clamp32((longint'(a) * 64'sd65536) / longint'(b)));
               end else begin
                  ans.status = rpn_pkg::ST_DIVZ;
               end
            end
            rpn_pkg::MODE_FINISH: begin
               value = calc_pop(under);
               use_top = 1'b0;
            end
            default: begin
               calc_halted = 1'b1;
               ans.status = rpn_pkg::ST_INVALID;
            end
         endcase
         if (under) ans.status = rpn_pkg::ST_UNDER;
      end
      if (use_top) value = (calc_depth > 0) ? calc_stack[calc_depth-1] : '0;
      ans.value = value;
      ans.depth = rpn_pkg::DEPTH_W'(calc_depth);
      return ans;
   endfunction

   // ------------------------------------------------------------------------
   // token sender: bursts of words with random gaps between them
   // ------------------------------------------------------------------------
   task automatic send_token(input logic [rpn_pkg::MODE_W-1:0] mode,
                             input logic signed [rpn_pkg::DATA_W-1:0] value);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if ($urandom_range(0, 2) != 0) gap = $urandom_range(1, 15);
      end
      burst_left--;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_number_value <= value;
      do begin
         @(posedge clock);
      end while (req_stall);
      pending_answers.push_back(calc_step(mode, value));
      tokens_sent++;
   endtask

   function automatic logic signed [rpn_pkg::DATA_W-1:0] pick_number();
      logic [rpn_pkg::DATA_W-1:0] r;
      case ($urandom_range(0, 7))
         0: r = Q_MAX;
         1: r = Q_MIN;
         2: r = '0;
         3, 4: begin
            // a few units either side of zero
            r = $urandom_range(0, 32'h0014_0000);
            r = r - 32'h000A_0000;
         end
         default: r = $urandom();
      endcase
      return r;
   endfunction

   function automatic logic [rpn_pkg::MODE_W-1:0] pick_arith();
      case ($urandom_range(0, 3))
         0: return rpn_pkg::MODE_ADD;
         1: return rpn_pkg::MODE_SUB;
         2: return rpn_pkg::MODE_MUL;
         default: return rpn_pkg::MODE_DIV;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // directed tests
   // ------------------------------------------------------------------------
   task automatic test_push_and_finish();
      send_token(rpn_pkg::MODE_PUSH, Q_MAX);
      send_token(rpn_pkg::MODE_FINISH, $urandom());
      send_token(rpn_pkg::MODE_PUSH, Q_MIN);
      send_token(rpn_pkg::MODE_FINISH, $urandom());
      // pop from an empty stack
      send_token(rpn_pkg::MODE_FINISH, $urandom());
   endtask

   task automatic test_add_sub_saturation();
      send_token(rpn_pkg::MODE_PUSH, Q_MAX);
      send_token(rpn_pkg::MODE_PUSH, 32'sd1);
      send_token(rpn_pkg::MODE_ADD, $urandom());
      send_token(rpn_pkg::MODE_PUSH, Q_MIN);
      send_token(rpn_pkg::MODE_SUB, $urandom());
      // one entry only, so the left operand underflows to zero
      send_token(rpn_pkg::MODE_SUB, $urandom());
      send_token(rpn_pkg::MODE_PUSH, -32'sd2);
      send_token(rpn_pkg::MODE_ADD, $urandom());
   endtask

   task automatic test_multiply();
      send_token(rpn_pkg::MODE_PUSH, Q_MIN);
      send_token(rpn_pkg::MODE_MUL, $urandom());
      send_token(rpn_pkg::MODE_PUSH, -32'sd1);
      send_token(rpn_pkg::MODE_MUL, $urandom());
      // negative product with a half, rounds down
      send_token(rpn_pkg::MODE_PUSH, 32'sd3);
      send_token(rpn_pkg::MODE_MUL, $urandom());
   endtask

   task automatic test_divide();
      send_token(rpn_pkg::MODE_PUSH, '0);
      send_token(rpn_pkg::MODE_DIV, $urandom());
      send_token(rpn_pkg::MODE_DIV, $urandom());
      send_token(rpn_pkg::MODE_FINISH, $urandom());
      // empty stack: underflow wins over divide by zero
      send_token(rpn_pkg::MODE_DIV, $urandom());
      send_token(rpn_pkg::MODE_PUSH, Q_MIN);
      send_token(rpn_pkg::MODE_PUSH, -Q_ONE);
      send_token(rpn_pkg::MODE_DIV, $urandom());
      send_token(rpn_pkg::MODE_FINISH, $urandom());
   endtask

   // ------------------------------------------------------------------------
   // random expressions, noise, drains and stack fills
   // ------------------------------------------------------------------------
   task automatic test_random_tokens();
      int target;
      int kind;
      int live;
      int steps;
      int fills;
      target = tokens_sent + RANDOM_TOKENS;
      fills = 0;
      kind = 19;
      while (tokens_sent < target) begin
         if (kind == 19 && fills < 2) begin
            // fill to the top, overflow, then work back down
            fills++;
            while (calc_depth < STACK_DEPTH)
               send_token(rpn_pkg::MODE_PUSH, pick_number());
            repeat ($urandom_range(1, 3)) send_token(rpn_pkg::MODE_PUSH, pick_number());
            while (calc_depth > 0)
               send_token($urandom_range(0, 1) ? rpn_pkg::MODE_FINISH : pick_arith(),
                          $urandom());
         end else if (kind < 13) begin
            // well-formed expression ending in finish
            send_token(rpn_pkg::MODE_PUSH, pick_number());
            send_token(rpn_pkg::MODE_PUSH, pick_number());
            live = 2;
            steps = $urandom_range(1, 8);
            repeat (steps) begin
               if (live < 2 || $urandom_range(0, 1)) begin
                  send_token(rpn_pkg::MODE_PUSH, pick_number());
                  live++;
               end else begin
                  send_token(pick_arith(), $urandom());
                  live--;
               end
            end
            while (live > 1) begin
               send_token(pick_arith(), $urandom());
               live--;
            end
            send_token(rpn_pkg::MODE_FINISH, $urandom());
         end else if (kind < 17) begin
            repeat ($urandom_range(1, 8))
               send_token(rpn_pkg::MODE_W'($urandom_range(rpn_pkg::MODE_PUSH,
                                                          rpn_pkg::MODE_FINISH)),
                          pick_number());
         end else begin
            // empty the stack and pop once more
            while (calc_depth > 0) send_token(rpn_pkg::MODE_FINISH, $urandom());
            send_token(rpn_pkg::MODE_FINISH, $urandom());
         end
         kind = $urandom_range(0, 19);
      end
   endtask

   // invalid token halts the block for the rest of the run
   task automatic test_halt();
      send_token(rpn_pkg::MODE_PUSH, Q_ONE);
      send_token(MODE_ILLEGAL_LO, $urandom());
      send_token(rpn_pkg::MODE_FINISH, $urandom());
      send_token(rpn_pkg::MODE_PUSH, pick_number());
      send_token(MODE_ILLEGAL_HI, $urandom());
      send_token(rpn_pkg::MODE_ADD, $urandom());
   endtask

   // ------------------------------------------------------------------------
   // response stall pattern: long quiet, light and heavy stretches
   // ------------------------------------------------------------------------
   int stall_style = 0;
   int style_left = 0;
   int stall_run = 0;

   always @(negedge clock) begin
      if (style_left == 0) begin
         stall_style = $urandom_range(0, 2);
         style_left = $urandom_range(100, 600);
      end else begin
         style_left--;
      end
      if (stall_run == 0) begin
         case (stall_style)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= $urandom_range(0, 1);
         endcase
         stall_run = $urandom_range(1, (stall_style == 2) ? 24 : 6);
      end else begin
         stall_run--;
      end
   end

   // ------------------------------------------------------------------------
   // response checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            $error("response word with no token outstanding");
            mismatches++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatches++;
            end
            if (rsp_result_value !== want.value) begin
               $error("result_value: expected %0d, got %0d",
                      $signed(want.value), rsp_result_value);
               mismatches++;
            end
            if (rsp_stack_depth !== want.depth) begin
               $error("stack_depth: expected %0d, got %0d", want.depth, rsp_stack_depth);
               mismatches++;
            end
         end
      end
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_push_and_finish();
      test_add_sub_saturation();
      test_multiply();
      test_divide();
      test_random_tokens();
      test_halt();

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
